// ===== design/csa_pkg.sv =====
// Shared constants, codes and control types for the classification score accumulator.
package csa_pkg;

    localparam int LABEL_W = 8;
    localparam int CNT_W = 21;
    localparam int Q_W = 17;
    localparam int NUM_W = CNT_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int NUM_CNT = 8;
    localparam int MAX_SAMPLES = 1048576;
    localparam int OUT_DATA_W = 104;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

    localparam int CNT_TOTAL = 0;
    localparam int CNT_CORRECT = 1;
    localparam int CNT_POS_TRUTH = 2;
    localparam int CNT_POS_PRED = 3;
    localparam int CNT_POS_HIT = 4;
    localparam int CNT_NEG_TRUTH = 5;
    localparam int CNT_NEG_PRED = 6;
    localparam int CNT_NEG_HIT = 7;

    typedef enum logic [2:0] {
        OP_ACC  = 3'd0,
        OP_PREC = 3'd1,
        OP_REC  = 3'd2,
        OP_F1P  = 3'd3,
        OP_F1N  = 3'd4
    } op_t;

    typedef struct packed {
        logic count_en;
        logic div_start;
        op_t  op;
        logic store_q;
        logic load_out;
    } csa_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } csa_stat_t;

endpackage

// ===== design/csa_div.sv =====
// Radix-2 restoring divider that returns a clamped Q1.16 ratio of two counts.
module csa_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [csa_pkg::NUM_W-1:0] num,
    input  logic [csa_pkg::NUM_W-1:0] den,
    output logic                      done,
    output logic [csa_pkg::Q_W-1:0]   quotient
);

    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic [3:0]                step_reg;
    logic [3:0]                step_next;
    logic [csa_pkg::NUM_W-1:0] den_reg;
    logic [csa_pkg::NUM_W-1:0] den_next;
    logic [csa_pkg::NUM_W-1:0] rem_reg;
    logic [csa_pkg::NUM_W-1:0] rem_next;
    logic [csa_pkg::Q_W-1:0]   quo_reg;
    logic [csa_pkg::Q_W-1:0]   quo_next;
    logic [csa_pkg::NUM_W:0]   shifted;

    assign shifted = {rem_reg, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            den_next = den;
            rem_next = num;
            quo_next = '0;
            if (den == '0)
            begin
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                quo_next = csa_pkg::Q_ONE;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = 4'(csa_pkg::FRAC_BITS - 1);
            end
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = csa_pkg::NUM_W'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[csa_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[csa_pkg::NUM_W-1:0];
                quo_next = {quo_reg[csa_pkg::Q_W-2:0], 1'b0};
            end
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/csa_datapath.sv =====
// Datapath: saturating counters, ratio operand selection, result registers and output register.
module csa_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  csa_pkg::csa_cmd_t                 cmd,
    output csa_pkg::csa_stat_t                stat,
    input  logic [csa_pkg::LABEL_W-1:0]       pos_class,
    input  logic [csa_pkg::LABEL_W-1:0]       neg_class,
    input  logic [csa_pkg::LABEL_W-1:0]       predicted_label,
    input  logic [csa_pkg::LABEL_W-1:0]       true_label,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [csa_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    logic [csa_pkg::CNT_W-1:0]      cnt_reg [csa_pkg::NUM_CNT];
    logic [csa_pkg::CNT_W-1:0]      cnt_next [csa_pkg::NUM_CNT];
    logic [csa_pkg::NUM_CNT-1:0]    inc;
    logic                           sat_reg;
    logic                           sat_next;
    logic                           pos_truth;
    logic                           pos_pred;
    logic                           neg_truth;
    logic                           neg_pred;
    logic [csa_pkg::NUM_W-1:0]      div_num;
    logic [csa_pkg::NUM_W-1:0]      div_den;
    logic                           div_done;
    logic [csa_pkg::Q_W-1:0]        div_q;
    logic [csa_pkg::Q_W-1:0]        acc_reg;
    logic [csa_pkg::Q_W-1:0]        prec_reg;
    logic [csa_pkg::Q_W-1:0]        rec_reg;
    logic [csa_pkg::Q_W-1:0]        f1p_reg;
    logic [csa_pkg::Q_W-1:0]        f1n_reg;
    logic [csa_pkg::Q_W:0]          f1_sum;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [csa_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_flag_reg;
    logic                           out_free;

    assign pos_truth = (true_label == pos_class);
    assign pos_pred = (predicted_label == pos_class);
    assign neg_truth = (true_label == neg_class);
    assign neg_pred = (predicted_label == neg_class);

    always_comb
    begin
        inc = '0;
        inc[csa_pkg::CNT_TOTAL] = 1'b1;
        inc[csa_pkg::CNT_CORRECT] = (predicted_label == true_label);
        inc[csa_pkg::CNT_POS_TRUTH] = pos_truth;
        inc[csa_pkg::CNT_POS_PRED] = pos_pred;
        inc[csa_pkg::CNT_POS_HIT] = pos_truth && pos_pred;
        inc[csa_pkg::CNT_NEG_TRUTH] = neg_truth;
        inc[csa_pkg::CNT_NEG_PRED] = neg_pred;
        inc[csa_pkg::CNT_NEG_HIT] = neg_truth && neg_pred;
    end

    always_comb
    begin
        sat_next = sat_reg;
        for (int i = 0; i < csa_pkg::NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (cmd.load_out)
            begin
                cnt_next[i] = '0;
            end
            else if (cmd.count_en && inc[i])
            begin
                if (cnt_reg[i] >= csa_pkg::CNT_MAX)
                begin
                    cnt_next[i] = csa_pkg::CNT_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    cnt_next[i] = cnt_reg[i] + csa_pkg::CNT_W'(1);
                end
            end
        end
        if (cmd.load_out)
        begin
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < csa_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            sat_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < csa_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            sat_reg <= sat_next;
        end
    end

    always_comb
    begin
        case (cmd.op)
            csa_pkg::OP_ACC:
            begin
                div_num = {1'b0, cnt_reg[csa_pkg::CNT_CORRECT]};
                div_den = {1'b0, cnt_reg[csa_pkg::CNT_TOTAL]};
            end
            csa_pkg::OP_PREC:
            begin
                div_num = {1'b0, cnt_reg[csa_pkg::CNT_POS_HIT]};
                div_den = {1'b0, cnt_reg[csa_pkg::CNT_POS_PRED]};
            end
            csa_pkg::OP_REC:
            begin
                div_num = {1'b0, cnt_reg[csa_pkg::CNT_POS_HIT]};
                div_den = {1'b0, cnt_reg[csa_pkg::CNT_POS_TRUTH]};
            end
            csa_pkg::OP_F1P:
            begin
                div_num = {cnt_reg[csa_pkg::CNT_POS_HIT], 1'b0};
                div_den = {1'b0, cnt_reg[csa_pkg::CNT_POS_PRED]}
                        + {1'b0, cnt_reg[csa_pkg::CNT_POS_TRUTH]};
            end
            csa_pkg::OP_F1N:
            begin
                div_num = {cnt_reg[csa_pkg::CNT_NEG_HIT], 1'b0};
                div_den = {1'b0, cnt_reg[csa_pkg::CNT_NEG_PRED]}
                        + {1'b0, cnt_reg[csa_pkg::CNT_NEG_TRUTH]};
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    csa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store_q)
        begin
            case (cmd.op)
                csa_pkg::OP_ACC:  acc_reg <= div_q;
                csa_pkg::OP_PREC: prec_reg <= div_q;
                csa_pkg::OP_REC:  rec_reg <= div_q;
                csa_pkg::OP_F1P:  f1p_reg <= div_q;
                csa_pkg::OP_F1N:  f1n_reg <= div_q;
                default:          acc_reg <= acc_reg;
            endcase
        end
    end

    assign f1_sum = {1'b0, f1p_reg} + {1'b0, f1n_reg};
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {2'b00, f1_sum[csa_pkg::Q_W:1], f1n_reg, f1p_reg,
                             rec_reg, prec_reg, acc_reg};
            out_flag_reg <= sat_reg;
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_flag_reg;

endmodule

// ===== design/csa_ctrl.sv =====
// Controller: counts pairs, then steps the shared divider through the five ratios.
module csa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    input  csa_pkg::csa_stat_t stat,
    output csa_pkg::csa_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_ACCUM = 4'b0001,
        ST_START = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    csa_pkg::op_t    op_reg;
    csa_pkg::op_t    op_next;
    csa_pkg::op_t    op_succ;

    always_comb
    begin
        case (op_reg)
            csa_pkg::OP_ACC:  op_succ = csa_pkg::OP_PREC;
            csa_pkg::OP_PREC: op_succ = csa_pkg::OP_REC;
            csa_pkg::OP_REC:  op_succ = csa_pkg::OP_F1P;
            csa_pkg::OP_F1P:  op_succ = csa_pkg::OP_F1N;
            default:          op_succ = csa_pkg::OP_ACC;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.op = op_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                s_tready = 1'b1;
                cmd.count_en = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    op_next = csa_pkg::OP_ACC;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.store_q = 1'b1;
                    if (op_reg == csa_pkg::OP_F1N)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        op_next = op_succ;
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            op_reg <= csa_pkg::OP_ACC;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

endmodule

// ===== design/classification_score_accumulator.sv =====
// Top level of the classification score accumulator: configuration port, controller and datapath.
//
// The block takes one (predicted, true) label pair per cycle and counts it in saturating
// counters. After the pair marked with tlast it stops taking pairs while one shared
// radix-2 divider works out accuracy, positive precision and recall, and positive and
// negative F1 in turn, each in Q1.16 with 65536 meaning 1.0. For each ratio the divider
// is loaded, works out 16 quotient bits and hands over the quotient; when the denominator
// is zero or the ratio is one it skips the bit steps and hands over 0 or 1.0. After
// the last pair s_tready stays low through the five ratios, and longer while an earlier
// result waits for m_tready. The result then moves to an output register, the counters
// clear, and pairs of the next batch are taken while that result waits for m_tready.
module classification_score_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,  // predicted_label[7:0], true_label[15:8]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,  // accuracy, pos_precision, pos_recall, f1_pos, f1_neg,
                                   // mean_f1 (17 bits each from bit 0), zero fill
    output logic         m_tuser   // overflow
);

    logic [csa_pkg::LABEL_W-1:0] pos_class_reg;
    logic [csa_pkg::LABEL_W-1:0] neg_class_reg;
    logic                        cfg_write;
    csa_pkg::csa_cmd_t           cmd;
    csa_pkg::csa_stat_t          stat;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_class_reg <= 8'd0;
            neg_class_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                neg_class_reg <= pwdata[csa_pkg::LABEL_W-1:0];
            end
            else
            begin
                pos_class_reg <= pwdata[csa_pkg::LABEL_W-1:0];
            end
        end
    end

    assign prdata = {24'd0, paddr[2] ? neg_class_reg : pos_class_reg};

    csa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csa_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .pos_class       (pos_class_reg),
        .neg_class       (neg_class_reg),
        .predicted_label (s_tdata[7:0]),
        .true_label      (s_tdata[15:8]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A batch end must stop intake while the ratios are computed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("pair taken while ratios are pending");

    // A new result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten before its transfer");

    // Pair counting and divider work never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_en |-> !(cmd.div_start || cmd.store_q || cmd.load_out))
        else $error("counting during ratio computation");

    // The mean F1 can never exceed one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[101:85] <= 17'd65536))
        else $error("mean F1 above one");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the classification score accumulator.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] REG_POS_CLASS = 3'd0;
    localparam logic [2:0] REG_NEG_CLASS = 3'd4;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int NUM_SCORES = 6;

    typedef struct {
        logic [csa_pkg::OUT_DATA_W-1:0] scores;
        logic                           overflow;
    } batch_score_t;

    class score_board;
        bit [csa_pkg::CNT_W-1:0]   tally [csa_pkg::NUM_CNT];
        bit                        saturated;
        bit [csa_pkg::LABEL_W-1:0] pos_label;
        bit [csa_pkg::LABEL_W-1:0] neg_label;
        batch_score_t              batch_scores [$];
        int                        errors;
        string                     field_names [NUM_SCORES] = '{"accuracy", "pos_precision",
                                                                "pos_recall", "f1_pos",
                                                                "f1_neg", "mean_f1"};

        function new();
            pos_label = 8'd0;
            neg_label = 8'd1;
            errors = 0;
            clear_tallies();
        endfunction

        function void clear_tallies();
            foreach (tally[k])
            begin
                tally[k] = '0;
            end
            saturated = 1'b0;
        endfunction

        function void bump(int idx);
            if (tally[idx] >= csa_pkg::CNT_MAX)
            begin
                tally[idx] = csa_pkg::CNT_MAX;
                saturated = 1'b1;
            end
            else
            begin
                tally[idx] = tally[idx] + csa_pkg::CNT_W'(1);
            end
        endfunction

        static function logic [csa_pkg::Q_W-1:0] q16_ratio(longint unsigned num,
                                                           longint unsigned den);
            longint unsigned q;
            if (den == 0)
            begin
                return '0;
            end
            q = (num << csa_pkg::FRAC_BITS) / den;
            if (q > 64'(csa_pkg::Q_ONE))
            begin
                return csa_pkg::Q_ONE;
            end
            return q[csa_pkg::Q_W-1:0];
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_pair(logic [csa_pkg::LABEL_W-1:0] pred,
                                logic [csa_pkg::LABEL_W-1:0] truth, logic last);
            batch_score_t              want;
            logic [csa_pkg::Q_W-1:0]   f1p;
            logic [csa_pkg::Q_W-1:0]   f1n;
            logic [csa_pkg::Q_W-1:0]   mean;
            bump(csa_pkg::CNT_TOTAL);
            if (pred == truth) bump(csa_pkg::CNT_CORRECT);
            if (truth == pos_label) bump(csa_pkg::CNT_POS_TRUTH);
            if (pred == pos_label) bump(csa_pkg::CNT_POS_PRED);
            if (truth == pos_label && pred == pos_label) bump(csa_pkg::CNT_POS_HIT);
            if (truth == neg_label) bump(csa_pkg::CNT_NEG_TRUTH);
            if (pred == neg_label) bump(csa_pkg::CNT_NEG_PRED);
            if (truth == neg_label && pred == neg_label) bump(csa_pkg::CNT_NEG_HIT);
            if (!last)
            begin
                return;
            end
            f1p = q16_ratio(2 * 64'(tally[csa_pkg::CNT_POS_HIT]),
                            64'(tally[csa_pkg::CNT_POS_PRED])
                            + 64'(tally[csa_pkg::CNT_POS_TRUTH]));
            f1n = q16_ratio(2 * 64'(tally[csa_pkg::CNT_NEG_HIT]),
                            64'(tally[csa_pkg::CNT_NEG_PRED])
                            + 64'(tally[csa_pkg::CNT_NEG_TRUTH]));
            mean = 17'((18'(f1p) + 18'(f1n)) >> 1);
            want.scores = {2'b00, mean, f1n, f1p,
                           q16_ratio(tally[csa_pkg::CNT_POS_HIT],
                                     tally[csa_pkg::CNT_POS_TRUTH]),
                           q16_ratio(tally[csa_pkg::CNT_POS_HIT],
                                     tally[csa_pkg::CNT_POS_PRED]),
                           q16_ratio(tally[csa_pkg::CNT_CORRECT],
                                     tally[csa_pkg::CNT_TOTAL])};
            want.overflow = saturated;
            batch_scores.push_back(want);
            clear_tallies();
        endfunction

        task check_result(logic [csa_pkg::OUT_DATA_W-1:0] data, logic flag);
            batch_score_t want;
            if (batch_scores.size() == 0)
            begin
                report("score transfer with no batch pending");
                return;
            end
            want = batch_scores.pop_front();
            for (int k = 0; k < NUM_SCORES; k++)
            begin
                if (data[k*csa_pkg::Q_W +: csa_pkg::Q_W]
                    !== want.scores[k*csa_pkg::Q_W +: csa_pkg::Q_W])
                begin
                    report($sformatf("%s got %0d expected %0d", field_names[k],
                                     data[k*csa_pkg::Q_W +: csa_pkg::Q_W],
                                     want.scores[k*csa_pkg::Q_W +: csa_pkg::Q_W]));
                end
            end
            if (flag !== want.overflow)
            begin
                report($sformatf("overflow got %b expected %b", flag, want.overflow));
            end
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;   // predicted_label[7:0], true_label[15:8]
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // accuracy, pos_precision, pos_recall, f1_pos, f1_neg,
                             // mean_f1 (17 bits each from bit 0), zero fill
    logic         m_tuser;   // overflow

    score_board  sb;
    bit          idle_en = 1'b1;
    bit          gappy_batch = 1'b1;
    int unsigned cycles = 0;

    classification_score_accumulator i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_pair(s_tdata[7:0], s_tdata[15:8], s_tlast);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (idle_en && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, value})
        begin
            sb.report($sformatf("register at %0d read %h expected %h", addr, prdata, value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.batch_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_classes(input logic [7:0] pos, input logic [7:0] neg);
        wait_drained();
        apb_write(REG_POS_CLASS, pos);
        apb_write(REG_NEG_CLASS, neg);
        sb.pos_label = pos;
        sb.neg_label = neg;
    endtask

    task automatic send_pair(input logic [7:0] pred, input logic [7:0] truth,
                             input logic last);
        int gap;
        gap = 0;
        if (idle_en && gappy_batch && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {truth, pred};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_label();
        case ($urandom_range(0, 3))
            0: return sb.pos_label;
            1: return sb.neg_label;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_batches(input int num_pairs);
        int          sent;
        int          len;
        logic [7:0]  pred;
        logic [7:0]  truth;
        sent = 0;
        while (sent < num_pairs)
        begin
            gappy_batch = ($urandom_range(0, 2) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                pred = pick_label();
                truth = ($urandom_range(0, 2) == 0) ? pred : pick_label();
                send_pair(pred, truth, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(8'd0, 8'd0, 1'b0);
        send_pair(8'd1, 8'd1, 1'b0);
        send_pair(8'd0, 8'd1, 1'b0);
        send_pair(8'd1, 8'd0, 1'b0);
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 1'b1);
        send_pair(8'd200, 8'd100, 1'b1);
        send_pair(8'd0, 8'd255, 1'b0);
        send_pair(8'hAA, 8'h55, 1'b0);
        send_pair(8'd1, 8'd1, 1'b1);

        set_classes(8'd255, 8'd0);
        send_pair(8'd255, 8'd255, 1'b0);
        send_pair(8'd0, 8'd0, 1'b0);
        send_pair(8'd255, 8'd0, 1'b0);
        send_pair(8'd0, 8'd255, 1'b1);
        run_batches(170);

        set_classes(8'd0, 8'd255);
        run_batches(170);

        // Both classes on one label: positive and negative tallies move together.
        set_classes(8'd7, 8'd7);
        run_batches(170);

        set_classes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_batches(170);

        set_classes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_batches(170);

        idle_en = 1'b0;
        set_classes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_batches(170);

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/csa_pkg.sv
design/csa_div.sv
design/csa_datapath.sv
design/csa_ctrl.sv
design/classification_score_accumulator.sv
dv/tb_top.sv
